@@ rtl/fha_pkg.sv @@
package fha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int MIN_TOTAL        = 16;

  localparam int KIND_W   = 2;
  localparam int REQ_W    = 13;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  typedef enum logic [2:0] {
    AS_HB,
    AS_CP,
    AS_NEXT,
    AS_SUCC,
    AS_HP,
    AS_REM
  } addr_sel_t;

  typedef enum logic [2:0] {
    WS_FMT,
    WS_NEG_REQ,
    WS_REM,
    WS_NEG_H,
    WS_SUM
  } wdata_sel_t;

  typedef enum logic {
    CP_INIT,
    CP_ADV
  } cp_sel_t;

  typedef enum logic {
    A_HDR,
    A_B
  } a_sel_t;

  typedef struct packed {
    logic                load_item;
    logic                fmt_init;
    logic                clr_step;
    logic                addr_load;
    addr_sel_t           addr_sel;
    logic                wdata_load;
    wdata_sel_t          wdata_sel;
    logic                mem_rd;
    logic                mem_wr;
    logic                hdr_clr;
    logic                cp_load;
    cp_sel_t             cp_sel;
    logic                a_load;
    a_sel_t              a_sel;
    logic                b_load;
    logic                guard_clr;
    logic                guard_inc;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_grant;
    logic                res_push;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              last_byte;
    logic              clr_last;
    logic              cp_lt_t;
    logic              fit;
    logic              hdr_pos;
    logic              a_pos;
    logic              b_pos;
    logic              brk;
    logic              guard_out;
    logic              free_bad;
    logic              out_free;
  } dp_stat_t;

endpackage

@@ rtl/fha_datapath.sv @@
module fha_datapath #(
  parameter int HEAP_BYTES   = fha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = fha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fha_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [fha_pkg::KIND_W-1:0]    kind,
  input  logic [fha_pkg::REQ_W-1:0]     request_size,
  input  logic [fha_pkg::OFF_W-1:0]     payload_offset,
  input  logic                          pointer_present,
  input  fha_pkg::dp_cmd_t              cmd,
  output fha_pkg::dp_stat_t             stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [fha_pkg::STATUS_W-1:0]  status,
  output logic [fha_pkg::OFF_W-1:0]     granted_offset
);

  localparam int HW       = 8 * HEADER_BYTES;
  localparam int AW       = $clog2(HEAP_BYTES + 1);
  localparam int IW       = $clog2(HEAP_BYTES);
  localparam int PW       = ((HW > AW) ? HW : AW) + 3;
  localparam int BW       = $clog2(HEADER_BYTES);
  localparam int WALK_CAP = 4 * HEAP_BYTES + 16;
  localparam int GW       = $clog2(WALK_CAP + 1);

  localparam logic signed [PW-1:0] HB_P         = PW'(HEADER_BYTES);
  localparam logic signed [PW-1:0] FIT_EXTRA    = PW'(HEADER_BYTES + 1);
  localparam logic signed [PW-1:0] FMT_OVERHEAD = PW'(2 * HEADER_BYTES);
  localparam logic signed [PW-1:0] MIN_P        = PW'(fha_pkg::MIN_TOTAL);
  localparam logic signed [PW-1:0] HEAP_P       = PW'(HEAP_BYTES);
  localparam logic [BW-1:0]        LAST_B       = BW'(HEADER_BYTES - 1);
  localparam logic [IW-1:0]        LAST_IDX     = IW'(HEAP_BYTES - 1);
  localparam logic [GW-1:0]        GUARD_MAX    = GW'(WALK_CAP);

  logic [fha_pkg::CFG_W-1:0]    heap_total_bytes;
  logic [AW-1:0]                total;
  logic [fha_pkg::KIND_W-1:0]   kind_q;
  logic [fha_pkg::REQ_W-1:0]    req_q;
  logic [fha_pkg::OFF_W-1:0]    poff_q;
  logic                         present_q;
  logic signed [PW-1:0]         cp;
  logic signed [PW-1:0]         addr;
  logic signed [HW-1:0]         a;
  logic signed [HW-1:0]         b;
  logic signed [HW-1:0]         hdr;
  logic [HW-1:0]                wdata;
  logic [BW-1:0]                bcnt;
  logic [IW-1:0]                clr_idx;
  logic [GW-1:0]                guard;
  logic                         rd_pend;
  logic [7:0]                   rdata;
  logic [7:0]                   mem [HEAP_BYTES];
  logic [fha_pkg::STATUS_W-1:0] res_status;
  logic [fha_pkg::OFF_W-1:0]    res_grant;

  logic signed [PW-1:0] total_p;
  logic signed [PW-1:0] req_p;
  logic signed [PW-1:0] poff_p;
  logic signed [PW-1:0] cfg_p;
  logic signed [PW-1:0] fmt_p;
  logic [HW-1:0]        fmt_h;
  logic signed [PW-1:0] eff_p;
  logic signed [PW-1:0] a_p;
  logic signed [PW-1:0] b_p;
  logic signed [PW-1:0] hdr_p;
  logic signed [PW-1:0] mag_a;
  logic signed [PW-1:0] cp_hb;
  logic signed [PW-1:0] addr_next;
  logic signed [PW-1:0] w_p;
  logic signed [PW-1:0] acc_p;
  logic [IW-1:0]        acc_idx;
  logic [7:0]           wbyte;

  assign total_p = {{(PW-AW){1'b0}}, total};
  assign req_p   = {{(PW-fha_pkg::REQ_W){1'b0}}, req_q};
  assign poff_p  = {{(PW-fha_pkg::OFF_W){1'b0}}, poff_q};
  assign cfg_p   = {{(PW-fha_pkg::CFG_W){1'b0}}, heap_total_bytes};
  assign a_p     = {{(PW-HW){a[HW-1]}}, a};
  assign b_p     = {{(PW-HW){b[HW-1]}}, b};
  assign hdr_p   = {{(PW-HW){hdr[HW-1]}}, hdr};
  assign mag_a   = a[HW-1] ? -a_p : a_p;
  assign cp_hb   = cp + HB_P;

  // saturated format size, then as read back through the leading word
  always_comb begin
    if (cfg_p < MIN_P) begin
      fmt_p = MIN_P;
    end else if (cfg_p > HEAP_P) begin
      fmt_p = HEAP_P;
    end else begin
      fmt_p = cfg_p;
    end
    fmt_h = fmt_p[HW-1:0];
    eff_p = fmt_h[HW-1] ? '0 : {{(PW-HW){1'b0}}, fmt_h};
  end

  always_comb begin
    unique case (cmd.addr_sel)
      fha_pkg::AS_HB:   addr_next = HB_P;
      fha_pkg::AS_CP:   addr_next = cp;
      fha_pkg::AS_NEXT: addr_next = cp_hb + mag_a;
      fha_pkg::AS_SUCC: addr_next = cp_hb + a_p;
      fha_pkg::AS_HP:   addr_next = poff_p - HB_P;
      fha_pkg::AS_REM:  addr_next = cp_hb + req_p;
      default:          addr_next = cp;
    endcase
  end

  always_comb begin
    unique case (cmd.wdata_sel)
      fha_pkg::WS_FMT:     w_p = fmt_p - FMT_OVERHEAD;
      fha_pkg::WS_NEG_REQ: w_p = -req_p;
      fha_pkg::WS_REM:     w_p = a_p - req_p - HB_P;
      fha_pkg::WS_NEG_H:   w_p = -hdr_p;
      fha_pkg::WS_SUM:     w_p = a_p + b_p + HB_P;
      default:             w_p = '0;
    endcase
  end

  assign acc_p   = addr + {{(PW-BW){1'b0}}, bcnt};
  assign acc_idx = acc_p[IW-1:0];
  assign wbyte   = wdata[{bcnt, 3'b000} +: 8];

  always_comb begin
    stat.kind      = kind_q;
    stat.in_range  = (addr >= HB_P) && (addr + HB_P <= total_p);
    stat.last_byte = (bcnt == LAST_B);
    stat.clr_last  = (clr_idx == LAST_IDX);
    stat.cp_lt_t   = (cp < total_p);
    stat.fit       = (hdr_p >= req_p + FIT_EXTRA);
    stat.hdr_pos   = (hdr > 0);
    stat.a_pos     = (a > 0);
    stat.b_pos     = (b > 0);
    stat.brk       = (a_p + cp_hb >= total_p);
    stat.guard_out = (guard == GUARD_MAX);
    stat.free_bad  = !present_q || (poff_p < FMT_OVERHEAD) || (poff_p > total_p);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_total_bytes <= fha_pkg::CFG_RESET;
      out_valid        <= 1'b0;
      rd_pend          <= 1'b0;
      bcnt             <= '0;
    end else begin
      if (cfg_we) begin
        heap_total_bytes <= cfg_wdata;
      end
      if (cmd.res_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= cmd.mem_rd;
      if (cmd.mem_rd || cmd.mem_wr) begin
        bcnt <= (bcnt == LAST_B) ? '0 : bcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q    <= kind;
      req_q     <= request_size;
      poff_q    <= payload_offset;
      present_q <= pointer_present;
    end
    if (cmd.fmt_init) begin
      total   <= eff_p[AW-1:0];
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
    if (cmd.addr_load) begin
      addr <= addr_next;
    end
    if (cmd.wdata_load) begin
      wdata <= w_p[HW-1:0];
    end
    if (cmd.hdr_clr) begin
      hdr <= '0;
    end else if (rd_pend) begin
      hdr <= {rdata, hdr[HW-1:8]};
    end
    if (cmd.cp_load) begin
      cp <= (cmd.cp_sel == fha_pkg::CP_INIT) ? HB_P : cp_hb + mag_a;
    end
    if (cmd.a_load) begin
      a <= (cmd.a_sel == fha_pkg::A_HDR) ? hdr : b;
    end
    if (cmd.b_load) begin
      b <= hdr;
    end
    if (cmd.guard_clr) begin
      guard <= '0;
    end else if (cmd.guard_inc) begin
      guard <= guard + 1'b1;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_grant  <= cmd.res_grant ? cp_hb[fha_pkg::OFF_W-1:0] : '0;
    end
    if (cmd.res_push) begin
      status         <= res_status;
      granted_offset <= res_grant;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_idx] <= '0;
    end else if (cmd.mem_wr) begin
      mem[acc_idx] <= wbyte;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[acc_idx];
    end
  end

endmodule

@@ rtl/fha_ctrl.sv @@
module fha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fha_pkg::dp_stat_t stat,
  output fha_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_RST,
    S_IDLE,
    S_DISPATCH,
    S_CLR,
    S_FMT_HDR,
    S_FMT_FIN,
    S_AL_LOOP,
    S_AL_TEST,
    S_AL_ADV,
    S_AL_REM,
    S_AL_FIN,
    S_FR_CHK,
    S_MW_INIT,
    S_MW_A0,
    S_MW_B0,
    S_MW_B1,
    S_MW_LOOP,
    S_MW_M1,
    S_MW_M2,
    S_MW_M3,
    S_MW_E1,
    S_RD_CHK,
    S_RD,
    S_RD_WAIT,
    S_WR_CHK,
    S_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  state_t ret;
  state_t ret_next;
  logic   quiet;
  logic   quiet_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    quiet_next = quiet;
    cmd        = '0;
    unique case (state)
      S_RST: begin
        cmd.fmt_init = 1'b1;
        quiet_next   = 1'b1;
        state_next   = S_CLR;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.kind)
          fha_pkg::KIND_ALLOC: begin
            cmd.cp_load = 1'b1;
            cmd.cp_sel  = fha_pkg::CP_INIT;
            state_next  = S_AL_LOOP;
          end
          fha_pkg::KIND_FREE: begin
            if (stat.free_bad) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = fha_pkg::ST_IGNORED;
              state_next   = S_DONE;
            end else begin
              cmd.addr_load = 1'b1;
              cmd.addr_sel  = fha_pkg::AS_HP;
              ret_next      = S_FR_CHK;
              state_next    = S_RD_CHK;
            end
          end
          fha_pkg::KIND_FORMAT: begin
            cmd.fmt_init = 1'b1;
            quiet_next   = 1'b0;
            state_next   = S_CLR;
          end
          default: begin
            cmd.res_set  = 1'b1;
            cmd.res_code = fha_pkg::ST_DONE;
            state_next   = S_DONE;
          end
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_FMT_HDR;
        end
      end
      S_FMT_HDR: begin
        cmd.addr_load  = 1'b1;
        cmd.addr_sel   = fha_pkg::AS_HB;
        cmd.wdata_load = 1'b1;
        cmd.wdata_sel  = fha_pkg::WS_FMT;
        ret_next       = S_FMT_FIN;
        state_next     = S_WR_CHK;
      end
      S_FMT_FIN: begin
        if (quiet) begin
          quiet_next = 1'b0;
          state_next = S_IDLE;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fha_pkg::ST_DONE;
          state_next   = S_DONE;
        end
      end
      S_AL_LOOP: begin
        if (!stat.cp_lt_t) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fha_pkg::ST_NOFIT;
          state_next   = S_DONE;
        end else begin
          cmd.addr_load = 1'b1;
          cmd.addr_sel  = fha_pkg::AS_CP;
          ret_next      = S_AL_TEST;
          state_next    = S_RD_CHK;
        end
      end
      S_AL_TEST: begin
        cmd.a_load = 1'b1;
        cmd.a_sel  = fha_pkg::A_HDR;
        if (stat.fit) begin
          cmd.wdata_load = 1'b1;
          cmd.wdata_sel  = fha_pkg::WS_NEG_REQ;
          ret_next       = S_AL_REM;
          state_next     = S_WR_CHK;
        end else begin
          state_next = S_AL_ADV;
        end
      end
      S_AL_ADV: begin
        cmd.cp_load = 1'b1;
        cmd.cp_sel  = fha_pkg::CP_ADV;
        state_next  = S_AL_LOOP;
      end
      S_AL_REM: begin
        cmd.addr_load  = 1'b1;
        cmd.addr_sel   = fha_pkg::AS_REM;
        cmd.wdata_load = 1'b1;
        cmd.wdata_sel  = fha_pkg::WS_REM;
        ret_next       = S_AL_FIN;
        state_next     = S_WR_CHK;
      end
      S_AL_FIN: begin
        cmd.res_set   = 1'b1;
        cmd.res_code  = fha_pkg::ST_DONE;
        cmd.res_grant = 1'b1;
        state_next    = S_DONE;
      end
      S_FR_CHK: begin
        if (stat.hdr_pos) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fha_pkg::ST_IGNORED;
          state_next   = S_DONE;
        end else begin
          cmd.wdata_load = 1'b1;
          cmd.wdata_sel  = fha_pkg::WS_NEG_H;
          ret_next       = S_MW_INIT;
          state_next     = S_WR_CHK;
        end
      end
      S_MW_INIT: begin
        cmd.cp_load   = 1'b1;
        cmd.cp_sel    = fha_pkg::CP_INIT;
        cmd.guard_clr = 1'b1;
        cmd.addr_load = 1'b1;
        cmd.addr_sel  = fha_pkg::AS_HB;
        ret_next      = S_MW_A0;
        state_next    = S_RD_CHK;
      end
      S_MW_A0: begin
        cmd.a_load = 1'b1;
        cmd.a_sel  = fha_pkg::A_HDR;
        state_next = S_MW_B0;
      end
      S_MW_B0: begin
        cmd.addr_load = 1'b1;
        cmd.addr_sel  = fha_pkg::AS_NEXT;
        ret_next      = S_MW_B1;
        state_next    = S_RD_CHK;
      end
      S_MW_B1: begin
        cmd.b_load = 1'b1;
        state_next = S_MW_LOOP;
      end
      S_MW_LOOP: begin
        if (!stat.cp_lt_t || stat.guard_out) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fha_pkg::ST_DONE;
          state_next   = S_DONE;
        end else begin
          cmd.guard_inc = 1'b1;
          if (stat.a_pos && stat.b_pos) begin
            cmd.wdata_load = 1'b1;
            cmd.wdata_sel  = fha_pkg::WS_SUM;
            cmd.addr_load  = 1'b1;
            cmd.addr_sel   = fha_pkg::AS_CP;
            ret_next       = S_MW_M1;
            state_next     = S_WR_CHK;
          end else begin
            cmd.cp_load = 1'b1;
            cmd.cp_sel  = fha_pkg::CP_ADV;
            cmd.a_load  = 1'b1;
            cmd.a_sel   = fha_pkg::A_B;
            state_next  = S_MW_E1;
          end
        end
      end
      S_MW_M1: begin
        ret_next   = S_MW_M2;
        state_next = S_RD_CHK;
      end
      S_MW_M2: begin
        cmd.a_load = 1'b1;
        cmd.a_sel  = fha_pkg::A_HDR;
        state_next = S_MW_M3;
      end
      S_MW_M3: begin
        if (stat.brk) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fha_pkg::ST_DONE;
          state_next   = S_DONE;
        end else begin
          cmd.addr_load = 1'b1;
          cmd.addr_sel  = fha_pkg::AS_SUCC;
          ret_next      = S_MW_B1;
          state_next    = S_RD_CHK;
        end
      end
      S_MW_E1: begin
        if (stat.brk) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = fha_pkg::ST_DONE;
          state_next   = S_DONE;
        end else begin
          cmd.addr_load = 1'b1;
          cmd.addr_sel  = fha_pkg::AS_NEXT;
          ret_next      = S_MW_B1;
          state_next    = S_RD_CHK;
        end
      end
      S_RD_CHK: begin
        if (stat.in_range) begin
          state_next = S_RD;
        end else begin
          cmd.hdr_clr = 1'b1;
          state_next  = ret;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        if (stat.last_byte) begin
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        state_next = ret;
      end
      S_WR_CHK: begin
        state_next = stat.in_range ? S_WR : ret;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        if (stat.last_byte) begin
          state_next = ret;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_push = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST;
      ret   <= S_IDLE;
      quiet <= 1'b1;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      quiet <= quiet_next;
    end
  end

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    kind, request_size, payload_offset, pointer_present
// out      output     out_valid / out_ready  status, granted_offset
// cfg      input      cfg_we                 cfg_wdata (heap_total_bytes)
//
// one item at a time; headers are read and written a byte at a time
// allocate: a first-fit walk, block by block
// free: steps over blocks and merges neighbouring free blocks
// format and reset clear the memory a byte a cycle, with in_ready low
// reset formats with heap_total_bytes at 4096 and gives no result
// a result waiting on out_ready holds back the next result; the next item is still taken
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = fha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = fha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fha_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fha_pkg::KIND_W-1:0]    kind,
  input  logic [fha_pkg::REQ_W-1:0]     request_size,
  input  logic [fha_pkg::OFF_W-1:0]     payload_offset,
  input  logic                          pointer_present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fha_pkg::STATUS_W-1:0]  status,
  output logic [fha_pkg::OFF_W-1:0]     granted_offset
);

  fha_pkg::dp_cmd_t  cmd;
  fha_pkg::dp_stat_t stat;

  fha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .kind            (kind),
    .request_size    (request_size),
    .payload_offset  (payload_offset),
    .pointer_present (pointer_present),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .status          (status),
    .granted_offset  (granted_offset)
  );

endmodule

@@ rtl/fha_checker.sv @@
module fha_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fha_pkg::STATUS_W-1:0] status,
  input logic [fha_pkg::OFF_W-1:0]    granted_offset
);

  // reset starts the clearing pass, so no item is taken right after it
  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_offset))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != fha_pkg::ST_DONE) |-> granted_offset == '0)
    else $error("offset given with a failing status");

  // a result is only produced while the input side is busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item in work");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while one is in work");

endmodule

bind first_fit_heap_allocator fha_checker u_fha_checker (.*);
